// File: rtl/pfd_pkg.sv
// pfd_pkg: shared types and constants of the ppm frame decoder
`default_nettype none

package pfd_pkg;

   // fixed field widths
   localparam int unsigned TIME_W  = 16;
   localparam int unsigned SLOT_W  = 4;
   localparam int unsigned SHIFT_W = 4;
   localparam int unsigned CSR_W   = 3;
   localparam int unsigned DATA_W  = 16;

   // slot at which the marker fires
   localparam logic [SLOT_W-1:0] MARKER_SLOT = 4'd6;

   // register reset values
   localparam logic [TIME_W-1:0]  SYNC_GAP_MIN_RST = 16'd20000;
   localparam logic [TIME_W-1:0]  PULSE_MIN_RST    = 16'd3000;
   localparam logic [TIME_W-1:0]  PULSE_MAX_RST    = 16'd9000;
   localparam logic [SHIFT_W-1:0] SCALE_SHIFT_RST  = 4'd2;
   localparam logic [TIME_W-1:0]  CLAMP_LOW_RST    = 16'd1000;
   localparam logic [TIME_W-1:0]  CLAMP_HIGH_RST   = 16'd2000;

   // register indexes
   typedef enum logic [CSR_W-1:0] {
      CSR_SYNC_GAP_MIN = 3'd0,
      CSR_PULSE_MIN    = 3'd1,
      CSR_PULSE_MAX    = 3'd2,
      CSR_SCALE_SHIFT  = 3'd3,
      CSR_CLAMP_LOW    = 3'd4,
      CSR_CLAMP_HIGH   = 3'd5
   } csr_index_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [TIME_W-1:0]  sync_gap_min;
      logic [TIME_W-1:0]  pulse_min;
      logic [TIME_W-1:0]  pulse_max;
      logic [SHIFT_W-1:0] scale_shift;
      logic [TIME_W-1:0]  clamp_low;
      logic [TIME_W-1:0]  clamp_high;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic [SLOT_W-1:0] slot_written;
      logic [TIME_W-1:0] channel_value;
      logic              frame_ok;
      logic              sync_seen;
      logic              marker;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/pfd_req_if.sv
// pfd_req_if: capture timestamp input channel
`default_nettype none

interface pfd_req_if;
   logic                         valid;
   logic                         ready;
   logic [pfd_pkg::TIME_W-1:0]   capture_time;

   modport source (output valid, output capture_time, input ready);
   modport sink   (input valid, input capture_time, output ready);
endinterface

`default_nettype wire

// File: rtl/pfd_rsp_if.sv
// pfd_rsp_if: decoded slot result channel
`default_nettype none

interface pfd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pfd_pkg::SLOT_W-1:0]   slot_written;
   logic [pfd_pkg::TIME_W-1:0]   channel_value;
   logic                         frame_ok;
   logic                         sync_seen;
   logic                         marker;

   modport source (output valid, output slot_written, output channel_value,
                   output frame_ok, output sync_seen, output marker, input ready);
   modport sink   (input valid, input slot_written, input channel_value,
                   input frame_ok, input sync_seen, input marker, output ready);
endinterface

`default_nettype wire

// File: rtl/pfd_csr_if.sv
// pfd_csr_if: configuration register write channel
`default_nettype none

interface pfd_csr_if;
   logic                         valid;
   logic                         ready;
   logic [pfd_pkg::CSR_W-1:0]    reg_index;
   logic [pfd_pkg::DATA_W-1:0]   wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// File: rtl/pfd_csr_regs.sv
// pfd_csr_regs: configuration registers of the ppm frame decoder
`default_nettype none

module pfd_csr_regs (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [pfd_pkg::CSR_W-1:0]     wr_index,
   input  wire logic [pfd_pkg::DATA_W-1:0]    wr_data,
   output pfd_pkg::cfg_type                   cfg
);

   pfd_pkg::cfg_type cfg_ff;
   pfd_pkg::cfg_type cfg_in;

   // decode a register write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (pfd_pkg::csr_index_type'(wr_index))
            pfd_pkg::CSR_SYNC_GAP_MIN: cfg_in.sync_gap_min = wr_data;
            pfd_pkg::CSR_PULSE_MIN:    cfg_in.pulse_min    = wr_data;
            pfd_pkg::CSR_PULSE_MAX:    cfg_in.pulse_max    = wr_data;
            pfd_pkg::CSR_SCALE_SHIFT:  cfg_in.scale_shift  = wr_data[pfd_pkg::SHIFT_W-1:0];
            pfd_pkg::CSR_CLAMP_LOW:    cfg_in.clamp_low    = wr_data;
            pfd_pkg::CSR_CLAMP_HIGH:   cfg_in.clamp_high   = wr_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_gap_min <= pfd_pkg::SYNC_GAP_MIN_RST;
         cfg_ff.pulse_min    <= pfd_pkg::PULSE_MIN_RST;
         cfg_ff.pulse_max    <= pfd_pkg::PULSE_MAX_RST;
         cfg_ff.scale_shift  <= pfd_pkg::SCALE_SHIFT_RST;
         cfg_ff.clamp_low    <= pfd_pkg::CLAMP_LOW_RST;
         cfg_ff.clamp_high   <= pfd_pkg::CLAMP_HIGH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/pfd_decode_core.sv
// pfd_decode_core: input register, slot decode logic and result register
`default_nettype none

module pfd_decode_core #(
   parameter int unsigned NUM_CHANNELS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pfd_pkg::cfg_type              cfg,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [pfd_pkg::TIME_W-1:0]    in_time,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output pfd_pkg::result_type                out_data
);

   localparam logic [pfd_pkg::SLOT_W-1:0] LAST_SLOT = pfd_pkg::SLOT_W'(NUM_CHANNELS);

   // input stage
   logic                          s1_valid_ff, s1_valid_in;
   logic [pfd_pkg::TIME_W-1:0]    s1_time_ff;
   // decoder state
   logic [pfd_pkg::TIME_W-1:0]    last_time_ff, last_time_in;
   logic [pfd_pkg::SLOT_W-1:0]    slot_count_ff, slot_count_in;
   logic                          status_ff, status_in;
   // result stage
   logic                          rsp_valid_ff, rsp_valid_in;
   pfd_pkg::result_type           rsp_data_ff, rsp_data_in;

   logic                          s1_advance;
   logic [pfd_pkg::TIME_W-1:0]    interval;
   logic [pfd_pkg::TIME_W-1:0]    shifted;
   logic [pfd_pkg::TIME_W-1:0]    clamped;
   logic                          is_sync;
   logic                          slot_live;
   logic                          in_window;
   logic [pfd_pkg::SLOT_W-1:0]    slot_base;

   // handshake: input stage moves on when the result register frees up
   assign s1_advance  = s1_valid_ff && (!rsp_valid_ff || out_ready);
   assign in_ready    = !s1_valid_ff || s1_advance;
   assign s1_valid_in = in_valid || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !out_ready);

   // interval and window tests
   assign interval  = s1_time_ff - last_time_ff;
   assign is_sync   = interval > cfg.sync_gap_min;
   assign slot_live = (slot_count_ff != '0) && (slot_count_ff <= LAST_SLOT);
   assign in_window = (interval > cfg.pulse_min) && (interval < cfg.pulse_max);

   // scale and clamp, lower bound checked first
   assign shifted = interval >> cfg.scale_shift;
   always_comb begin
      priority if (shifted < cfg.clamp_low) begin
         clamped = cfg.clamp_low;
      end else if (shifted > cfg.clamp_high) begin
         clamped = cfg.clamp_high;
      end else begin
         clamped = shifted;
      end
   end

   // slot decode and next state
   always_comb begin
      slot_base    = slot_count_ff;
      status_in    = status_ff;
      rsp_data_in  = '0;
      priority if (is_sync) begin
         slot_base = '0;
      end else if (slot_live) begin
         if (in_window) begin
            rsp_data_in.slot_written  = slot_count_ff;
            rsp_data_in.channel_value = clamped;
            if (slot_count_ff == LAST_SLOT) begin
               status_in = 1'b1;
            end
         end else begin
            status_in = 1'b0;
         end
      end else begin
         status_in = 1'b0;
         slot_base = '0;
      end
      rsp_data_in.frame_ok  = status_in;
      rsp_data_in.sync_seen = is_sync;
      rsp_data_in.marker    = (slot_base == pfd_pkg::MARKER_SLOT);
      slot_count_in         = slot_base + 1'b1;
      last_time_in          = s1_time_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         last_time_ff  <= '0;
         slot_count_ff <= '0;
         status_ff     <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_advance) begin
            last_time_ff  <= last_time_in;
            slot_count_ff <= slot_count_in;
            status_ff     <= status_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_time_ff <= in_time;
      end
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: rtl/ppm_frame_decoder.sv
// ppm_frame_decoder: top level of the pulse-position frame decoder
//
//   channel  | dir | payload                                          | accepted when
//   ---------+-----+--------------------------------------------------+--------------
//   req_ch   | in  | capture_time                                     | valid & ready
//   rsp_ch   | out | slot_written channel_value frame_ok sync_seen marker | valid & ready
//   csr_ch   | in  | reg_index wr_data                                | valid & ready
//
// one item per cycle sustained while rsp_ch is ready; the accepting edge loads
// the input register, and the item moves on into the result register once that
// register is free; a result is shown and taken from the result register
// reset is synchronous; it restores register defaults and clears the slot
// counter, last timestamp and frame status
// a stalled result holds in the result register while one more item waits
// in the input register; csr writes are always taken
`default_nettype none

module ppm_frame_decoder #(
   parameter int unsigned NUM_CHANNELS = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pfd_req_if.sink     req_ch,
   pfd_rsp_if.source   rsp_ch,
   pfd_csr_if.sink     csr_ch
);

   pfd_pkg::cfg_type    cfg;
   pfd_pkg::result_type rsp_data;

   // configuration registers
   assign csr_ch.ready = 1'b1;

   pfd_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.reg_index),
      .wr_data  (csr_ch.wr_data),
      .cfg      (cfg)
   );

   // decode datapath
   pfd_decode_core #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_decode_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_time   (req_ch.capture_time),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_data)
   );

   // result fields
   assign rsp_ch.slot_written  = rsp_data.slot_written;
   assign rsp_ch.channel_value = rsp_data.channel_value;
   assign rsp_ch.frame_ok      = rsp_data.frame_ok;
   assign rsp_ch.sync_seen     = rsp_data.sync_seen;
   assign rsp_ch.marker        = rsp_data.marker;

endmodule

`default_nettype wire

// File: rtl/pfd_checker.sv
// pfd_checker: port-level assertions for the ppm frame decoder
`default_nettype none

module pfd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [pfd_pkg::SLOT_W-1:0]    slot_written,
   input wire logic [pfd_pkg::TIME_W-1:0]    channel_value,
   input wire logic                          frame_ok,
   input wire logic                          sync_seen,
   input wire logic                          marker
);

   // a stalled result stays valid and keeps its slot, value and frame status
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(slot_written)
         && $stable(channel_value) && $stable(frame_ok))
      else $error("result changed while stalled");

   // no stored slot means a zero value
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (slot_written == '0) |-> (channel_value == '0))
      else $error("channel value without a stored slot");

   // a sync gap never stores a slot
   a_sync_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sync_seen |-> (slot_written == '0))
      else $error("slot stored on a sync gap");

   // a sync gap restarts the counter, so the marker cannot fire with it
   a_sync_no_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sync_seen |-> !marker)
      else $error("marker on a sync gap");

endmodule

bind ppm_frame_decoder pfd_checker u_pfd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .slot_written  (rsp_ch.slot_written),
   .channel_value (rsp_ch.channel_value),
   .frame_ok      (rsp_ch.frame_ok),
   .sync_seen     (rsp_ch.sync_seen),
   .marker        (rsp_ch.marker)
);

`default_nettype wire
